// ===== rtl/core/tel_pkg.sv =====
// Shared types and constants for the temporal edge relaxation block.
package tel_pkg;

  // Field widths of the request and result items
  localparam int VERTEX_W = 12;
  localparam int WEIGHT_W = 16;
  localparam int TIME_W   = 32;
  localparam int DIST_W   = 32;
  localparam int REQ_W    = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 72;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Initial values for a vertex other than the query source
  localparam logic [DIST_W-1:0] DIST_INF = 32'h3FFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_INF = 32'h7FFF_FFFF;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_RELAX = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_INIT  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_END     = 2'd2;

  // Query configuration as seen by front and back
  typedef struct packed {
    logic [VERTEX_W-1:0]      origin_vertex;
    logic signed [TIME_W-1:0] query_start;
    logic signed [TIME_W-1:0] query_end;
  } cfg_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    req_e                       req;
    logic                       in_range;   // all addressed vertices exist
    logic                       in_window;  // edge overlaps the query interval
    logic                       end_ok;     // edge ends inside the query interval
    logic                       is_source;  // addressed vertex is the query source
    logic [VERTEX_W-1:0]        from_vertex;
    logic [VERTEX_W-1:0]        to_vertex;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [TIME_W-1:0]   begin_time;
    logic signed [TIME_W-1:0]   finish_time;
  } item_t;

  // Result item, newly_visited in the lowest bit
  typedef struct packed {
    logic              vertex_visited;
    logic [TIME_W-1:0] vertex_arrival;
    logic [DIST_W-1:0] vertex_distance;
    logic              newly_visited;
  } result_t;

endpackage

// ===== rtl/core/tel_front.sv =====
// Front end: accepts requests from the input stream and classifies them.
module tel_front
  import tel_pkg::*;
#(
  parameter int VERTICES = 4096
) (
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // from_vertex, to_vertex, weight, begin_time, finish_time (lowest bit up)
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [REQ_W-1:0]     s_axis_tuser,
  input  cfg_t                 cfg_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output item_t                item_o
);

  localparam logic [31:0] VCOUNT = 32'(VERTICES);

  logic [VERTEX_W-1:0]        from_v;
  logic [VERTEX_W-1:0]        to_v;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [TIME_W-1:0]   begin_t;
  logic signed [TIME_W-1:0]   finish_t;
  req_e                       req;
  logic                       to_ok;
  logic                       from_ok;

  // Unpack the payload
  assign from_v   = s_axis_tdata[11:0];
  assign to_v     = s_axis_tdata[23:12];
  assign weight   = $signed(s_axis_tdata[39:24]);
  assign begin_t  = $signed(s_axis_tdata[71:40]);
  assign finish_t = $signed(s_axis_tdata[103:72]);
  assign req      = req_e'(s_axis_tuser);

  // Check that the addressed vertices exist
  assign to_ok   = 32'(to_v) < VCOUNT;
  assign from_ok = 32'(from_v) < VCOUNT;

  // Classify the request against the query interval
  always_comb begin
    item_o.req         = req;
    item_o.in_range    = to_ok && (from_ok || (req != REQ_RELAX));
    item_o.in_window   = ($signed(begin_t) < $signed(cfg_i.query_end)) &&
                         ($signed(finish_t) > $signed(cfg_i.query_start));
    item_o.end_ok      = $signed(finish_t) <= $signed(cfg_i.query_end);
    item_o.is_source   = to_v == cfg_i.origin_vertex;
    item_o.from_vertex = from_v;
    item_o.to_vertex   = to_v;
    item_o.weight      = weight;
    item_o.begin_time  = begin_t;
    item_o.finish_time = finish_t;
  end

  // Take a transfer whenever the queue has room and reset is not asserted
  assign s_axis_tready = !queue_full_i && rst_ni;
  assign push_o        = s_axis_tvalid && s_axis_tready;

endmodule

// ===== rtl/core/tel_queue.sv =====
// Short queue of classified requests between front and back.
module tel_queue
  import tel_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/tel_back.sv =====
// Back end: vertex stores and the read, evaluate and write sequencer.
module tel_back
  import tel_pkg::*;
#(
  parameter int VERTICES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  queue_empty_i,
  input  item_t                 head_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // newly_visited, vertex_distance, vertex_arrival, vertex_visited (lowest bit up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int DEPTH = (VERTICES < (1 << VERTEX_W)) ? VERTICES : (1 << VERTEX_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_EVAL = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  // Vertex stores
  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [TIME_W-1:0] arr_mem  [DEPTH];
  logic              vis_mem  [DEPTH];

  item_t             item_q;
  logic [DIST_W-1:0] dist_from_q, dist_to_q;
  logic [TIME_W-1:0] arr_from_q, arr_to_q;
  logic              vis_to_q;
  logic [DIST_W-1:0] cand_q, cand_d;
  logic              time_ok_q, time_ok_d;
  logic              out_valid_q;
  result_t           out_q, out_d;

  logic [AW-1:0]     rd_from_addr;
  logic [AW-1:0]     rd_to_addr;
  logic [AW-1:0]     wr_addr;
  logic              upd;
  logic              wr_dist, wr_arr, wr_vis;
  logic [DIST_W-1:0] wdist;
  logic [TIME_W-1:0] warr;
  logic              wvis;
  logic [DIST_W:0]   sum;

  // Pop only when the output register is free or drains this cycle
  assign pop_o = (state_q == BK_IDLE) && !queue_empty_i &&
                 (!out_valid_q || m_axis_tready);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_o) state_d = BK_READ;
      BK_READ: state_d = BK_EVAL;
      BK_EVAL: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the popped request
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
  end

  assign rd_from_addr = head_i.from_vertex[AW-1:0];
  assign rd_to_addr   = head_i.to_vertex[AW-1:0];
  assign wr_addr      = item_q.to_vertex[AW-1:0];

  // Saturating candidate distance and arrival checks
  always_comb begin
    sum       = {dist_from_q[DIST_W-1], dist_from_q} +
                {{(DIST_W + 1 - WEIGHT_W){item_q.weight[WEIGHT_W-1]}}, item_q.weight};
    cand_d    = sum[DIST_W-1:0];
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand_d = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end
    time_ok_d = ($signed(item_q.begin_time) >= $signed(arr_from_q)) &&
                ($signed(item_q.finish_time) < $signed(arr_to_q));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_READ) begin
      cand_q    <= cand_d;
      time_ok_q <= time_ok_d;
    end
  end

  // Decide the store update and the result
  always_comb begin
    upd     = item_q.in_range && item_q.in_window && item_q.end_ok && time_ok_q &&
              ($signed(dist_to_q) > $signed(cand_q));
    wr_dist = 1'b0;
    wr_arr  = 1'b0;
    wr_vis  = 1'b0;
    wdist   = cand_q;
    warr    = item_q.finish_time;
    wvis    = 1'b1;
    out_d.newly_visited   = 1'b0;
    out_d.vertex_distance = dist_to_q;
    out_d.vertex_arrival  = arr_to_q;
    out_d.vertex_visited  = vis_to_q;
    unique case (item_q.req)
      REQ_RELAX: begin
        if (upd) begin
          wr_dist = 1'b1;
          wr_arr  = 1'b1;
          wr_vis  = 1'b1;
          out_d.newly_visited   = !vis_to_q;
          out_d.vertex_distance = cand_q;
          out_d.vertex_arrival  = item_q.finish_time;
          out_d.vertex_visited  = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wr_vis = 1'b1;
        wvis   = 1'b0;
        out_d.vertex_visited = 1'b0;
      end
      REQ_INIT: begin
        wr_dist = 1'b1;
        wr_arr  = 1'b1;
        wr_vis  = 1'b1;
        wvis    = 1'b0;
        wdist   = item_q.is_source ? '0 : DIST_INF;
        warr    = item_q.is_source ? cfg_i.query_start : TIME_INF;
        out_d.vertex_distance = wdist;
        out_d.vertex_arrival  = warr;
        out_d.vertex_visited  = 1'b0;
      end
      REQ_READ: begin
        out_d.vertex_visited = vis_to_q;
      end
      default: begin
        out_d.vertex_visited = vis_to_q;
      end
    endcase
    // Drop everything for a vertex that does not exist
    if (!item_q.in_range) begin
      wr_dist = 1'b0;
      wr_arr  = 1'b0;
      wr_vis  = 1'b0;
      out_d   = '0;
    end
  end

  // Store access: two reads at pop, one write at evaluate
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dist_from_q <= dist_mem[rd_from_addr];
      dist_to_q   <= dist_mem[rd_to_addr];
      arr_from_q  <= arr_mem[rd_from_addr];
      arr_to_q    <= arr_mem[rd_to_addr];
      vis_to_q    <= vis_mem[rd_to_addr];
    end
    if ((state_q == BK_EVAL) && wr_dist) begin
      dist_mem[wr_addr] <= wdist;
    end
    if ((state_q == BK_EVAL) && wr_arr) begin
      arr_mem[wr_addr] <= warr;
    end
    if ((state_q == BK_EVAL) && wr_vis) begin
      vis_mem[wr_addr] <= wvis;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == BK_EVAL) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_EVAL) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_q};

endmodule

// ===== rtl/core/temporal_edge_relaxation.sv =====
// Path: an accepted transfer passes the queue, the read and evaluate states and the
//   output register. The back end takes a new request only once its read, evaluate and
//   write pass over the single write port of the vertex stores is done; a 2-entry queue
//   lets the front keep taking transfers while the back works or the output stalls.
// Reset: clears control state and loads the query registers with their defaults;
//   the vertex stores are undefined until an init request writes each vertex.
module temporal_edge_relaxation
  import tel_pkg::*;
#(
  parameter int VERTICES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // from_vertex, to_vertex, weight, begin_time, finish_time (lowest bit up)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [REQ_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // newly_visited, vertex_distance, vertex_arrival, vertex_visited (lowest bit up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  item_t push_item;
  item_t head;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_vertex <= '0;
      cfg_q.query_start   <= '0;
      cfg_q.query_end     <= TIME_INF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SOURCE_VERTEX: cfg_q.origin_vertex <= cfg_data_i[VERTEX_W-1:0];
        CFG_QUERY_START:   cfg_q.query_start   <= cfg_data_i;
        CFG_QUERY_END:     cfg_q.query_end     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tel_front #(
    .VERTICES(VERTICES)
  ) u_front (
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_i        (cfg_q),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  tel_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  tel_back #(
    .VERTICES(VERTICES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .queue_empty_i(empty),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

// ===== rtl/core/tel_checker.sv =====
// Port-level checks for the temporal edge relaxation block, bound to the top level.
module tel_checker
  import tel_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A result waiting for the sink holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A newly visited vertex is reported as visited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[65])
    else $error("newly visited vertex reported as not visited");

  // No result is offered right after reset
  assert property (@(posedge clk_i)
    (rst_ni && $past(!rst_ni)) |-> !m_axis_tvalid)
    else $error("result offered directly after reset");

endmodule

bind temporal_edge_relaxation tel_checker u_tel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== test/temporal_edge_relaxation_tb.sv =====
// Self-checking testbench for temporal_edge_relaxation: directed table, random query phases.
`timescale 1ns / 100ps

module temporal_edge_relaxation_tb
  import tel_pkg::*;
();

  localparam int VERTICES      = 4096;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 135;
  localparam int PRINT_CAP     = 40;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [TIME_W-1:0]   S32_MIN = 32'sh8000_0000;
  localparam logic signed [TIME_W-1:0]   S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WEIGHT_W-1:0] W_MIN   = 16'sh8000;
  localparam logic signed [WEIGHT_W-1:0] W_MAX   = 16'sh7FFF;

  typedef struct {
    req_e                       req;
    logic [VERTEX_W-1:0]        from_v;
    logic [VERTEX_W-1:0]        to_v;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [TIME_W-1:0]   t_begin;
    logic signed [TIME_W-1:0]   t_finish;
  } request_t;

  typedef struct {
    request_t rq;
    bit       fixed;  // result written out in the table, not predicted
    result_t  want;
  } table_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predicted vertex stores and query registers
  logic signed [DIST_W-1:0] dist_mem    [VERTICES];
  logic signed [TIME_W-1:0] arrival_mem [VERTICES];
  logic                     visited_mem [VERTICES];
  logic [VERTEX_W-1:0]      q_source = '0;
  logic signed [TIME_W-1:0] q_start = '0;
  logic signed [TIME_W-1:0] q_end = S32_MAX;

  result_t     pending_results [$];
  table_row_t  directed_rows [$];
  int unsigned error_count = 0;
  int unsigned result_index = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  temporal_edge_relaxation #(
    .VERTICES(VERTICES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("%0t ns: ERROR %s", $time, msg);
    end
  endtask

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // Apply one request to the predicted stores and return the result it causes.
  // Every 12-bit vertex number exists at this depth, so no request is out of range.
  function automatic result_t relax_predict(input request_t rq);
    result_t                  res;
    logic signed [DIST_W-1:0] cand;
    res = '0;
    case (rq.req)
      REQ_RELAX: begin
        if (rq.t_begin < q_end && rq.t_finish > q_start) begin
          cand = clamp_s32(longint'(dist_mem[rq.from_v]) + longint'(rq.weight));
          if (rq.t_finish <= q_end && rq.t_begin >= arrival_mem[rq.from_v] &&
              rq.t_finish < arrival_mem[rq.to_v] && dist_mem[rq.to_v] > cand) begin
            arrival_mem[rq.to_v] = rq.t_finish;
            dist_mem[rq.to_v]    = cand;
            if (!visited_mem[rq.to_v]) begin
              visited_mem[rq.to_v] = 1'b1;
              res.newly_visited    = 1'b1;
            end
          end
        end
      end
      REQ_CLEAR: visited_mem[rq.to_v] = 1'b0;
      REQ_INIT: begin
        if (rq.to_v == q_source) begin
          dist_mem[rq.to_v]    = '0;
          arrival_mem[rq.to_v] = q_start;
        end else begin
          dist_mem[rq.to_v]    = DIST_INF;
          arrival_mem[rq.to_v] = TIME_INF;
        end
        visited_mem[rq.to_v] = 1'b0;
      end
      REQ_READ: ;
    endcase
    res.vertex_distance = dist_mem[rq.to_v];
    res.vertex_arrival  = arrival_mem[rq.to_v];
    res.vertex_visited  = visited_mem[rq.to_v];
    return res;
  endfunction

  function automatic void add_row(input req_e kind, input logic [VERTEX_W-1:0] f, t,
                                  input logic signed [WEIGHT_W-1:0] w,
                                  input logic signed [TIME_W-1:0] tb, te,
                                  input bit fixed = 1'b0, input logic nv = 1'b0,
                                  input logic [31:0] d = '0, input logic [31:0] a = '0,
                                  input logic vis = 1'b0);
    table_row_t row;
    row.rq.req      = kind;
    row.rq.from_v   = f;
    row.rq.to_v     = t;
    row.rq.weight   = w;
    row.rq.t_begin  = tb;
    row.rq.t_finish = te;
    row.fixed       = fixed;
    row.want.newly_visited   = nv;
    row.want.vertex_distance = d;
    row.want.vertex_arrival  = a;
    row.want.vertex_visited  = vis;
    directed_rows.push_back(row);
  endfunction

  // Request of one kind with every field it does not use left random
  function automatic request_t any_request(input req_e kind, input logic [VERTEX_W-1:0] f, t);
    request_t rq;
    rq.req      = kind;
    rq.from_v   = f;
    rq.to_v     = t;
    rq.weight   = WEIGHT_W'($urandom);
    rq.t_begin  = $urandom;
    rq.t_finish = $urandom;
    return rq;
  endfunction

  // Edge that leaves the tail shortly after it was reached
  function automatic request_t timed_edge(input logic [VERTEX_W-1:0] f, t);
    request_t rq;
    rq = any_request(REQ_RELAX, f, t);
    if ($urandom_range(0, 19) == 0) begin
      rq.weight = $urandom_range(0, 1) ? W_MIN : W_MAX;
    end else begin
      rq.weight = WEIGHT_W'(int'($urandom_range(0, 300)) - 100);
    end
    rq.t_begin  = clamp_s32(longint'(arrival_mem[f]) + longint'($urandom_range(0, 20)));
    rq.t_finish = clamp_s32(longint'(rq.t_begin) + longint'($urandom_range(1, 60)));
    return rq;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold one request until its transfer, then queue the result it should cause
  task automatic send_request(input request_t rq, input bit fixed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.req;
    s_axis_tdata  <= {rq.t_finish, rq.t_begin, rq.weight, rq.to_v, rq.from_v};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = relax_predict(rq);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SOURCE_VERTEX: q_source = val[VERTEX_W-1:0];
      CFG_QUERY_START:   q_start = val;
      CFG_QUERY_END:     q_end = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_query(input logic [VERTEX_W-1:0] src,
                           input logic signed [TIME_W-1:0] qs, qe);
    write_reg(CFG_SPARE, $urandom);
    write_reg(CFG_SOURCE_VERTEX, CFG_DATA_W'(src));
    write_reg(CFG_QUERY_START, qs);
    write_reg(CFG_QUERY_END, qe);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Init a small vertex pool, then mostly timed edges inside it with some noise
  task automatic run_phase(input int n_items);
    logic [VERTEX_W-1:0] pool [$];
    logic [VERTEX_W-1:0] f, t;
    request_t            rq;
    int unsigned         roll;
    pool.push_back(q_source);
    repeat ($urandom_range(3, 11)) pool.push_back(VERTEX_W'($urandom));
    foreach (pool[i]) begin
      send_request(any_request(REQ_INIT, VERTEX_W'($urandom), pool[i]), 1'b0, '0);
    end
    repeat (n_items) begin
      // prefer a tail that has already been reached
      f = pool[$urandom_range(0, pool.size() - 1)];
      repeat (3) begin
        if (arrival_mem[f] == S32_MAX) f = pool[$urandom_range(0, pool.size() - 1)];
      end
      t = pool[$urandom_range(0, pool.size() - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 68) rq = timed_edge(f, t);
      else if (roll < 76) rq = any_request(REQ_CLEAR, f, t);
      else if (roll < 84) rq = any_request(REQ_READ, f, t);
      else if (roll < 89) rq = any_request(REQ_INIT, f, t);
      else if (roll < 95) rq = any_request(REQ_RELAX, f, t);
      else rq = any_request(REQ_INIT, f, VERTEX_W'($urandom));
      send_request(rq, 1'b0, '0);
    end
  endtask

  // Random stalls on the result side
  initial begin : sink_stall
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) stall_left = pick_gap(sink_idle_on);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing pending", result_index));
      end else begin
        want = pending_results.pop_front();
        if (got.newly_visited !== want.newly_visited) begin
          report_error($sformatf("result %0d newly_visited %b, want %b", result_index,
                                 got.newly_visited, want.newly_visited));
        end
        if (got.vertex_distance !== want.vertex_distance) begin
          report_error($sformatf("result %0d vertex_distance %h, want %h", result_index,
                                 got.vertex_distance, want.vertex_distance));
        end
        if (got.vertex_arrival !== want.vertex_arrival) begin
          report_error($sformatf("result %0d vertex_arrival %h, want %h", result_index,
                                 got.vertex_arrival, want.vertex_arrival));
        end
        if (got.vertex_visited !== want.vertex_visited) begin
          report_error($sformatf("result %0d vertex_visited %b, want %b", result_index,
                                 got.vertex_visited, want.vertex_visited));
        end
      end
      result_index++;
    end
  end

  // End the run once no transfer has happened for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic signed [TIME_W-1:0] qs;

    // Directed rows run with the registers at their reset values
    add_row(REQ_INIT,  12'h000, 12'h000, 16'sd0, 0, 0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(REQ_INIT,  12'h000, 12'hFFF, 16'sd0, 0, 0, 1'b1, 1'b0, DIST_INF, TIME_INF, 1'b0);
    add_row(REQ_INIT,  12'h000, 12'h001, 16'sd0, 0, 0, 1'b1, 1'b0, DIST_INF, TIME_INF, 1'b0);
    add_row(REQ_READ,  12'hFFF, 12'h000, W_MAX, S32_MAX, S32_MIN,
            1'b1, 1'b0, 32'd0, 32'd0, 1'b0);
    // first visit of a vertex
    add_row(REQ_RELAX, 12'h000, 12'hFFF, W_MIN, 0, 10,
            1'b1, 1'b1, 32'hFFFF_8000, 32'd10, 1'b1);
    add_row(REQ_RELAX, 12'h000, 12'hFFF, 16'sd100, 0, 5);
    add_row(REQ_RELAX, 12'hFFF, 12'h001, W_MAX, 10, 20);
    // head not reached any earlier
    add_row(REQ_RELAX, 12'hFFF, 12'h001, -16'sd5, 10, 20);
    // edge leaves before the tail is reached
    add_row(REQ_RELAX, 12'hFFF, 12'h001, -16'sd5, 9, 15);
    // edge begins at the query end, then ends at the query start
    add_row(REQ_RELAX, 12'h000, 12'h001, -16'sd9, S32_MAX, 15);
    add_row(REQ_RELAX, 12'h000, 12'h001, -16'sd9, S32_MIN, 0);
    // clear the mark, then visit again through a begin later than the finish
    add_row(REQ_CLEAR, 12'h000, 12'hFFF, 16'sd0, 0, 0);
    add_row(REQ_RELAX, 12'h001, 12'hFFF, W_MIN, 20, 8);
    add_row(REQ_READ,  12'h000, 12'hFFF, 16'sd0, 0, 0);
    add_row(REQ_INIT,  12'h000, 12'h001, 16'sd0, 0, 0, 1'b1, 1'b0, DIST_INF, TIME_INF, 1'b0);
    add_row(REQ_CLEAR, 12'h000, 12'h001, 16'sd0, 0, 0);
    // edge ending at the largest time never beats an unreached head
    add_row(REQ_RELAX, 12'h000, 12'h001, 16'sd0, 0, S32_MAX);
    add_row(REQ_READ,  12'h000, 12'h001, 16'sd0, 0, 0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].want);
    end
    drain();

    // Random phases, each under its own query and idle pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      src_idle_on  = (p % 4) < 2;
      sink_idle_on = (p % 4) == 0 || (p % 4) == 2;
      case (p)
        0: set_query(12'h000, S32_MIN, S32_MAX);
        1: set_query(12'hFFF, S32_MAX, S32_MIN);
        5: set_query(VERTEX_W'($urandom), $urandom, $urandom);
        default: begin
          qs = $signed($urandom) >>> 1;
          set_query(VERTEX_W'($urandom), qs,
                    clamp_s32(longint'(qs) + longint'($urandom_range(50, 3000))));
        end
      endcase
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
